// ----- hw/rtl/assert_macros.svh -----
// Assertion macros used by the checker file of this block.
// No dependencies; include by bare file name.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Property that must hold at every clock edge outside reset.
`define SRSW_ASSERT(lbl, clk, rst_n, prop) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (prop)) \
		else $error("assertion failed");

// Implication checked at every clock edge outside reset.
`define SRSW_ASSERT_IMP(lbl, clk, rst_n, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error("implication failed");

`endif

// ----- hw/rtl/srsw_pkg.sv -----
// Types and constants of the selective-repeat sender window.
// No dependencies; used by every module of the block.
`default_nettype none

package srsw_pkg;

	localparam int SEQ_SPACE = 8;
	localparam int SEQ_W     = $clog2(SEQ_SPACE);
	localparam int WIN_W     = 3;
	localparam logic [WIN_W-1:0] WIN_RESET = 3'd4;
	localparam int WORD_W    = 64;

	// Input tdata: payload_word, ack_number, ack_good, expired_seq
	localparam int IN_ACK_LO   = WORD_W;
	localparam int IN_GOOD_BIT = IN_ACK_LO + SEQ_W;
	localparam int IN_EXP_LO   = IN_GOOD_BIT + 1;
	localparam int IN_DATA_W   = 72;

	// Output tdata field positions
	localparam int OUT_ACC_BIT  = 0;
	localparam int OUT_PV_BIT   = 1;
	localparam int OUT_PSEQ_LO  = 2;
	localparam int OUT_PAY_LO   = OUT_PSEQ_LO + SEQ_W;
	localparam int OUT_TCMD_LO  = OUT_PAY_LO + WORD_W;
	localparam int OUT_TSEQ_LO  = OUT_TCMD_LO + 2;
	localparam int OUT_BASE_LO  = OUT_TSEQ_LO + SEQ_W;
	localparam int OUT_NEXT_LO  = OUT_BASE_LO + SEQ_W;
	localparam int OUT_FULL_BIT = OUT_NEXT_LO + SEQ_W;
	localparam int OUT_USED_W   = OUT_FULL_BIT + 1;
	localparam int OUT_DATA_W   = 88;

	typedef enum logic [1:0] {
		ACT_SEND   = 2'd0,
		ACT_ACK    = 2'd1,
		ACT_EXPIRE = 2'd2,
		ACT_NONE   = 2'd3
	} act_t;

	typedef enum logic [1:0] {
		TMR_NONE    = 2'd0,
		TMR_START   = 2'd1,
		TMR_STOP    = 2'd2,
		TMR_RESTART = 2'd3
	} tcmd_t;

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_EXEC,
		ST_SLIDE,
		ST_DONE
	} state_t;

	typedef struct packed {
		logic             we;
		logic [SEQ_W-1:0] waddr;
		logic             re;
		logic [SEQ_W-1:0] raddr;
	} mem_ctl_t;

	typedef struct packed {
		logic              send_accepted;
		logic              packet_valid;
		logic [SEQ_W-1:0]  packet_seq;
		logic [WORD_W-1:0] packet_payload;
		tcmd_t             timer_command;
		logic [SEQ_W-1:0]  timer_seq;
		logic [SEQ_W-1:0]  window_base;
		logic [SEQ_W-1:0]  next_sequence;
		logic              window_full;
	} res_t;

endpackage

`default_nettype wire

// ----- hw/rtl/srsw_pmem.sv -----
// Payload store: one synchronous memory, one write and one read port,
// registered read data. Uses srsw_pkg.
`default_nettype none

module srsw_pmem #(
	parameter int DATA_W = 64
) (
	input  wire                   clk,
	input  srsw_pkg::mem_ctl_t    ctl,
	input  wire  [DATA_W-1:0]     wdata,
	output logic [DATA_W-1:0]     rdata
);
	import srsw_pkg::*;

	logic [DATA_W-1:0] mem [SEQ_SPACE];

	always_ff @(posedge clk) begin
		if (ctl.we) begin
			mem[ctl.waddr] <= wdata;
		end
	end

	always_ff @(posedge clk) begin
		if (ctl.re) begin
			rdata <= mem[ctl.raddr];
		end
	end

endmodule

`default_nettype wire

// ----- hw/rtl/srsw_ctrl.sv -----
// Window controller: base and next counters, acked flags, item sequencer
// and base slide walk. Uses srsw_pkg; drives the srsw_pmem ports.
`default_nettype none

module srsw_ctrl #(
	parameter int PAYLOAD_BITS = 64
) (
	input  wire                               clk,
	input  wire                               arst_n,
	input  wire                               in_valid,
	output logic                              in_ready,
	input  srsw_pkg::act_t                    in_action,
	input  wire  [PAYLOAD_BITS-1:0]           in_word,
	input  wire  [srsw_pkg::SEQ_W-1:0]        in_ackn,
	input  wire                               in_good,
	input  wire  [srsw_pkg::SEQ_W-1:0]        in_expn,
	input  wire  [srsw_pkg::WIN_W-1:0]        window_size,
	output srsw_pkg::mem_ctl_t                mem_ctl,
	output logic [PAYLOAD_BITS-1:0]           mem_wdata,
	input  wire  [PAYLOAD_BITS-1:0]           mem_rdata,
	output logic                              res_valid,
	input  wire                               res_ready,
	output srsw_pkg::res_t                    res
);
	import srsw_pkg::*;

	state_t                  state_q, state_d;
	logic [SEQ_W-1:0]        base_q, next_q;
	logic [SEQ_SPACE-1:0]    flags_q;
	act_t                    act_q;
	logic [PAYLOAD_BITS-1:0] word_q;
	logic [SEQ_W-1:0]        ackn_q, expn_q;
	logic                    good_q;
	res_t                    ev_q, ev_d;

	logic [SEQ_W-1:0] dist_next, dist_ack;
	logic [WIN_W-1:0] eff_win;
	logic             full, in_window, slide_go, accept;

	assign dist_next = next_q - base_q;
	assign dist_ack  = ackn_q - base_q;
	assign eff_win   = (window_size > WIN_W'(SEQ_SPACE - 1)) ?
		WIN_W'(SEQ_SPACE - 1) : window_size;
	assign full      = dist_next >= SEQ_W'(eff_win);
	assign in_window = dist_ack < dist_next;
	assign slide_go  = (base_q != next_q) && flags_q[base_q];
	assign accept    = in_valid && in_ready;

	// Next state
	always_comb begin
		state_d = state_q;
		case (state_q)
			ST_IDLE: begin
				if (in_valid) begin
					state_d = ST_EXEC;
				end
			end
			ST_EXEC: begin
				if (act_q == ACT_ACK && good_q && in_window) begin
					state_d = ST_SLIDE;
				end else begin
					state_d = ST_DONE;
				end
			end
			ST_SLIDE: begin
				if (!slide_go) begin
					state_d = ST_DONE;
				end
			end
			ST_DONE: begin
				if (res_ready) begin
					state_d = ST_IDLE;
				end
			end
			default: state_d = ST_IDLE;
		endcase
	end

	// Outputs
	always_comb begin
		in_ready      = (state_q == ST_IDLE);
		mem_ctl.re    = accept && (in_action == ACT_EXPIRE);
		mem_ctl.raddr = in_expn;
		mem_ctl.we    = (state_q == ST_EXEC) && (act_q == ACT_SEND) && !full;
		mem_ctl.waddr = next_q;
		mem_wdata     = word_q;
		res_valid     = (state_q == ST_DONE);
		res               = ev_q;
		res.window_base   = base_q;
		res.next_sequence = next_q;
		res.window_full   = full;
	end

	// Event part of the result, settled in the execute cycle
	always_comb begin
		ev_d = '0;
		ev_d.timer_command = TMR_NONE;
		case (act_q)
			ACT_SEND: begin
				if (!full) begin
					ev_d.send_accepted  = 1'b1;
					ev_d.packet_valid   = 1'b1;
					ev_d.packet_seq     = next_q;
					ev_d.packet_payload = WORD_W'(word_q);
					ev_d.timer_command  = TMR_START;
					ev_d.timer_seq      = next_q;
				end
			end
			ACT_ACK: begin
				if (good_q) begin
					ev_d.timer_command = TMR_STOP;
					ev_d.timer_seq     = ackn_q;
				end
			end
			ACT_EXPIRE: begin
				ev_d.packet_valid   = 1'b1;
				ev_d.packet_seq     = expn_q;
				ev_d.packet_payload = WORD_W'(mem_rdata);
				ev_d.timer_command  = TMR_RESTART;
				ev_d.timer_seq      = expn_q;
			end
			default: ev_d = '0;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			base_q  <= '0;
			next_q  <= '0;
			flags_q <= '0;
		end else begin
			state_q <= state_d;
			if (state_q == ST_EXEC) begin
				if (act_q == ACT_SEND && !full) begin
					flags_q[next_q] <= 1'b0;
					next_q          <= next_q + 1'b1;
				end
				if (act_q == ACT_ACK && good_q && in_window) begin
					flags_q[ackn_q] <= 1'b1;
				end
			end
			// Walk the base past acked slots, one per cycle
			if (state_q == ST_SLIDE && slide_go) begin
				flags_q[base_q] <= 1'b0;
				base_q          <= base_q + 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			act_q  <= in_action;
			word_q <= in_word;
			ackn_q <= in_ackn;
			good_q <= in_good;
			expn_q <= in_expn;
		end
		if (state_q == ST_EXEC) begin
			ev_q <= ev_d;
		end
	end

endmodule

`default_nettype wire

// ----- hw/rtl/selective_repeat_sender_window_core.sv -----
// Top level of the selective-repeat sender window: stream ports, window
// register, output register. Uses srsw_pkg, srsw_ctrl and srsw_pmem.
`default_nettype none

// One item is in work at a time. A send, an expiry, a corrupt or stray
// acknowledgement and a no-op item each pass through accept (which issues
// the payload memory read), execute (memory write for a send, read data for
// an expiry) and deliver into the output register. The next item can be
// accepted in the cycle after delivery. A good acknowledgement that falls
// in the window adds a slide step between execute and deliver, in which the
// base slides past the acked slots, one flag per cycle. While the output
// register holds an unread result, the block waits in its deliver cycle. The
// next item is taken while the previous result waits in the output register.
// window_size resets to 4 and is written through cfg_valid/cfg_data; the user
// must write it only while the block is idle, which the block does not enforce.
module selective_repeat_sender_window_core #(
	parameter int PAYLOAD_BITS = 64
) (
	input  wire                                clk,
	input  wire                                arst_n,
	input  wire                                s_axis_tvalid,
	output logic                               s_axis_tready,
	// [63:0] payload_word, [66:64] ack_number, [67] ack_good,
	// [70:68] expired_seq, [71] zero
	input  wire  [srsw_pkg::IN_DATA_W-1:0]     s_axis_tdata,
	// [1:0] action
	input  wire  [1:0]                         s_axis_tuser,
	output logic                               m_axis_tvalid,
	input  wire                                m_axis_tready,
	// [0] send_accepted, [1] packet_valid, [4:2] packet_seq,
	// [68:5] packet_payload, [70:69] timer_command, [73:71] timer_seq,
	// [76:74] window_base, [79:77] next_sequence, [80] window_full, [87:81] zero
	output logic [srsw_pkg::OUT_DATA_W-1:0]    m_axis_tdata,
	input  wire                                cfg_valid,
	output logic                               cfg_ready,
	input  wire  [srsw_pkg::WIN_W-1:0]         cfg_data
);
	import srsw_pkg::*;

	logic [WIN_W-1:0]        window_size_q;
	mem_ctl_t                mem_ctl;
	logic [PAYLOAD_BITS-1:0] mem_wdata, mem_rdata;
	logic                    res_valid, res_ready;
	res_t                    res;
	logic                    out_valid_q;
	logic [OUT_DATA_W-1:0]   out_data_q;

	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			window_size_q <= WIN_RESET;
		end else if (cfg_valid && cfg_ready) begin
			window_size_q <= cfg_data;
		end
	end

	srsw_ctrl #(
		.PAYLOAD_BITS(PAYLOAD_BITS)
	) u_ctrl (
		.clk        (clk),
		.arst_n     (arst_n),
		.in_valid   (s_axis_tvalid),
		.in_ready   (s_axis_tready),
		.in_action  (act_t'(s_axis_tuser)),
		.in_word    (s_axis_tdata[PAYLOAD_BITS-1:0]),
		.in_ackn    (s_axis_tdata[IN_ACK_LO +: SEQ_W]),
		.in_good    (s_axis_tdata[IN_GOOD_BIT]),
		.in_expn    (s_axis_tdata[IN_EXP_LO +: SEQ_W]),
		.window_size(window_size_q),
		.mem_ctl    (mem_ctl),
		.mem_wdata  (mem_wdata),
		.mem_rdata  (mem_rdata),
		.res_valid  (res_valid),
		.res_ready  (res_ready),
		.res        (res)
	);

	srsw_pmem #(
		.DATA_W(PAYLOAD_BITS)
	) u_pmem (
		.clk  (clk),
		.ctl  (mem_ctl),
		.wdata(mem_wdata),
		.rdata(mem_rdata)
	);

	// Output register: load when empty or being drained
	assign res_ready = !out_valid_q || m_axis_tready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (res_ready) begin
			out_valid_q <= res_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (res_valid && res_ready) begin
			out_data_q <= {
				(OUT_DATA_W - OUT_USED_W)'(0),
				res.window_full,
				res.next_sequence,
				res.window_base,
				res.timer_seq,
				res.timer_command,
				res.packet_payload,
				res.packet_seq,
				res.packet_valid,
				res.send_accepted
			};
		end
	end

	assign m_axis_tvalid = out_valid_q;
	assign m_axis_tdata  = out_data_q;

endmodule

`default_nettype wire

// ----- hw/rtl/srsw_chk.sv -----
// Port-level checker for the selective-repeat sender window and its bind.
// Uses srsw_pkg and assert_macros.svh.
`default_nettype none
`include "assert_macros.svh"

module srsw_chk (
	input wire                               clk,
	input wire                               arst_n,
	input wire                               m_axis_tvalid,
	input wire                               m_axis_tready,
	input wire [srsw_pkg::OUT_DATA_W-1:0]    m_axis_tdata
);
	import srsw_pkg::*;

	logic             acc, pv;
	logic [SEQ_W-1:0] pseq, tseq;
	logic [1:0]       tcmd;

	assign acc  = m_axis_tdata[OUT_ACC_BIT];
	assign pv   = m_axis_tdata[OUT_PV_BIT];
	assign pseq = m_axis_tdata[OUT_PSEQ_LO +: SEQ_W];
	assign tcmd = m_axis_tdata[OUT_TCMD_LO +: 2];
	assign tseq = m_axis_tdata[OUT_TSEQ_LO +: SEQ_W];

	// Hold a stalled result
	`SRSW_ASSERT_IMP(a_out_hold, clk, arst_n, m_axis_tvalid && !m_axis_tready, ##1 $stable(m_axis_tdata))

	// An accepted send emits its packet and starts the same timer
	`SRSW_ASSERT_IMP(a_send_start, clk, arst_n, m_axis_tvalid && acc, pv && tcmd == TMR_START && pseq == tseq)

	// No packet means zero sequence and payload
	`SRSW_ASSERT_IMP(a_no_pkt_zero, clk, arst_n, m_axis_tvalid && !pv, pseq == '0 && m_axis_tdata[OUT_PAY_LO +: WORD_W] == '0)

	// No timer command means a zero timer sequence
	`SRSW_ASSERT_IMP(a_no_tmr_zero, clk, arst_n, m_axis_tvalid && tcmd == TMR_NONE, tseq == '0)

endmodule

bind selective_repeat_sender_window_core srsw_chk u_srsw_chk (.*);

`default_nettype wire

// ----- dv/tb.sv -----
// Self-checking bench for selective_repeat_sender_window_core: streams send, ack and
// expiry items, predicts every result item in a scoreboard class and compares field by field.
// Depends on srsw_pkg and the core RTL only.
`default_nettype none

module tb;
	import srsw_pkg::*;

	localparam int PHASE_ITEMS = 156;
	localparam int STALL_LIMIT = 2000;
	localparam int DRAIN_CYCLES = 16;

	class sender_window_scoreboard;
		logic [SEQ_W-1:0]  base;
		logic [SEQ_W-1:0]  nxt;
		logic [WIN_W-1:0]  win;
		bit                acked[SEQ_SPACE];
		bit                written[SEQ_SPACE];
		logic [WORD_W-1:0] stored[SEQ_SPACE];
		res_t              awaited_results[$];
		int failures, checked;
		int sends_taken, sends_refused, acks_in_window, acks_other, expiries;

		function new();
			base = '0;
			nxt = '0;
			win = WIN_RESET;
			foreach (acked[i]) begin
				acked[i] = 1'b0;
				written[i] = 1'b0;
			end
		endfunction

		function logic [SEQ_W-1:0] in_flight();
			return nxt - base;
		endfunction

		function bit full();
			logic [WIN_W-1:0] w;
			w = (win > SEQ_SPACE - 1) ? WIN_W'(SEQ_SPACE - 1) : win;
			return in_flight() >= w;
		endfunction

		// Note one accepted input item and queue the result it must produce.
		function void take_item(act_t act, logic [WORD_W-1:0] pay, logic [SEQ_W-1:0] ackn,
				logic good, logic [SEQ_W-1:0] expn);
			res_t r;
			logic [SEQ_W-1:0] ack_dist;
			r = '0;
			r.timer_command = TMR_NONE;
			case (act)
				ACT_SEND: begin
					if (!full()) begin
						acked[nxt] = 1'b0;
						stored[nxt] = pay;
						written[nxt] = 1'b1;
						r.send_accepted = 1'b1;
						r.packet_valid = 1'b1;
						r.packet_seq = nxt;
						r.packet_payload = pay;
						r.timer_command = TMR_START;
						r.timer_seq = nxt;
						nxt = nxt + 1'b1;
						sends_taken++;
					end else begin
						sends_refused++;
					end
				end
				ACT_ACK: begin
					if (good) begin
						r.timer_command = TMR_STOP;
						r.timer_seq = ackn;
						ack_dist = ackn - base;
						if (ack_dist < in_flight()) begin
							acked[ackn] = 1'b1;
							// slide past every acked slot, clearing each
							while (base != nxt && acked[base]) begin
								acked[base] = 1'b0;
								base = base + 1'b1;
							end
							acks_in_window++;
						end else begin
							acks_other++;
						end
					end
				end
				ACT_EXPIRE: begin
					r.packet_valid = 1'b1;
					r.packet_seq = expn;
					r.packet_payload = stored[expn];
					r.timer_command = TMR_RESTART;
					r.timer_seq = expn;
					expiries++;
				end
				default: ;
			endcase
			r.window_base = base;
			r.next_sequence = nxt;
			r.window_full = full();
			awaited_results.push_back(r);
		endfunction

		function void report(string what, logic [WORD_W-1:0] want, logic [WORD_W-1:0] got);
			failures++;
			if (failures <= 10)
				$display("result %0d %s: expected %0h, got %0h", checked, what, want, got);
		endfunction

		function void compare(string what, logic [WORD_W-1:0] want, logic [WORD_W-1:0] got);
			if (want !== got)
				report(what, want, got);
		endfunction

		// Check one accepted result item against the oldest expectation.
		function void match_result(logic [OUT_DATA_W-1:0] d);
			res_t want;
			if (awaited_results.size() == 0) begin
				report("unexpected result item", '0, d[WORD_W-1:0]);
				return;
			end
			want = awaited_results.pop_front();
			compare("send_accepted", want.send_accepted, d[OUT_ACC_BIT]);
			compare("packet_valid", want.packet_valid, d[OUT_PV_BIT]);
			compare("packet_seq", want.packet_seq, d[OUT_PSEQ_LO +: SEQ_W]);
			compare("packet_payload", want.packet_payload, d[OUT_PAY_LO +: WORD_W]);
			compare("timer_command", want.timer_command, d[OUT_TCMD_LO +: 2]);
			compare("timer_seq", want.timer_seq, d[OUT_TSEQ_LO +: SEQ_W]);
			compare("window_base", want.window_base, d[OUT_BASE_LO +: SEQ_W]);
			compare("next_sequence", want.next_sequence, d[OUT_NEXT_LO +: SEQ_W]);
			compare("window_full", want.window_full, d[OUT_FULL_BIT]);
			compare("padding", '0, d[OUT_DATA_W-1:OUT_USED_W]);
			checked++;
		endfunction

		function void close_out();
			if (awaited_results.size() != 0) begin
				$display("%0d expected result items never arrived", awaited_results.size());
				failures += awaited_results.size();
			end
		endfunction
	endclass

	logic                    clk = 1'b0;
	logic                    arst_n = 1'b0;
	logic                    s_axis_tvalid = 1'b0;
	wire                     s_axis_tready;
	// [63:0] payload_word, [66:64] ack_number, [67] ack_good, [70:68] expired_seq, [71] zero
	logic [IN_DATA_W-1:0]    s_axis_tdata = '0;
	// [1:0] action
	logic [1:0]              s_axis_tuser = '0;
	wire                     m_axis_tvalid;
	logic                    m_axis_tready = 1'b0;
	// [0] send_accepted, [1] packet_valid, [4:2] packet_seq, [68:5] packet_payload,
	// [70:69] timer_command, [73:71] timer_seq, [76:74] window_base,
	// [79:77] next_sequence, [80] window_full, [87:81] zero
	wire  [OUT_DATA_W-1:0]   m_axis_tdata;
	logic                    cfg_valid = 1'b0;
	wire                     cfg_ready;
	logic [WIN_W-1:0]        cfg_data = '0;

	sender_window_scoreboard board;
	bit steady = 1'b0;
	int stall_left = 0;
	int idle_cycles = 0;
	int settings_used = 0;
	int windows[$] = '{1, 7, 0, 3, 5, 2, 6, 7};

	selective_repeat_sender_window_core dut (
		.clk           (clk),
		.arst_n        (arst_n),
		.s_axis_tvalid (s_axis_tvalid),
		.s_axis_tready (s_axis_tready),
		.s_axis_tdata  (s_axis_tdata),
		.s_axis_tuser  (s_axis_tuser),
		.m_axis_tvalid (m_axis_tvalid),
		.m_axis_tready (m_axis_tready),
		.m_axis_tdata  (m_axis_tdata),
		.cfg_valid     (cfg_valid),
		.cfg_ready     (cfg_ready),
		.cfg_data      (cfg_data)
	);

	always #10 clk = ~clk;

	// Receiver: ready most of the time, with stall bursts until the steady part.
	always @(posedge clk) begin
		if (stall_left > 0) begin
			stall_left <= stall_left - 1;
			m_axis_tready <= 1'b0;
		end else if (!steady && $urandom_range(0, 9) == 0) begin
			stall_left <= $urandom_range(1, 15) - 1;
			m_axis_tready <= 1'b0;
		end else begin
			m_axis_tready <= 1'b1;
		end
	end

	always @(posedge clk) begin
		if (arst_n && m_axis_tvalid && m_axis_tready)
			board.match_result(m_axis_tdata);
	end

	always @(posedge clk) begin
		if (!arst_n || (s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready)
				|| (cfg_valid && cfg_ready)) begin
			idle_cycles <= 0;
		end else if (idle_cycles == STALL_LIMIT) begin
			$display("no handshake for %0d cycles, %0d results still awaited",
				STALL_LIMIT, board.awaited_results.size());
			$display("Simulation FAILED");
			$finish;
		end else begin
			idle_cycles <= idle_cycles + 1;
		end
	end

	task automatic offer_item(input act_t act, input logic [WORD_W-1:0] pay,
			input logic [SEQ_W-1:0] ackn, input logic good, input logic [SEQ_W-1:0] expn);
		if (!steady && $urandom_range(0, 5) == 0) begin
			s_axis_tvalid <= 1'b0;
			repeat ($urandom_range(1, 15)) @(posedge clk);
		end
		s_axis_tvalid <= 1'b1;
		s_axis_tdata <= {1'b0, expn, good, ackn, pay};
		s_axis_tuser <= act;
		@(posedge clk);
		while (!s_axis_tready) @(posedge clk);
		board.take_item(act, pay, ackn, good, expn);
	endtask

	// Wait until every result is in and any slide still running has finished.
	task automatic settle();
		while (board.awaited_results.size() != 0) @(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);
	endtask

	task automatic write_window(input logic [WIN_W-1:0] w);
		cfg_valid <= 1'b1;
		cfg_data <= w;
		@(posedge clk);
		while (!cfg_ready) @(posedge clk);
		cfg_valid <= 1'b0;
		board.win = w;
		settings_used++;
	endtask

	function automatic logic [WORD_W-1:0] pick_payload();
		case ($urandom_range(0, 7))
			0: return '1;
			1: return '0;
			default: return {$urandom, $urandom};
		endcase
	endfunction

	task automatic run_directed();
		offer_item(ACT_NONE, pick_payload(), 3'd7, 1'b1, 3'd5);
		offer_item(ACT_ACK, '0, 3'd0, 1'b1, 3'd0);           // ack with nothing sent
		offer_item(ACT_SEND, '1, 3'd7, 1'b0, 3'd7);
		offer_item(ACT_SEND, '0, 3'd0, 1'b1, 3'd0);
		offer_item(ACT_SEND, 64'hA5A5_A5A5_A5A5_A5A5, 3'd0, 1'b0, 3'd0);
		offer_item(ACT_SEND, 64'h5A5A_5A5A_5A5A_5A5A, 3'd0, 1'b0, 3'd0);
		offer_item(ACT_SEND, 64'h0123_4567_89AB_CDEF, 3'd0, 1'b0, 3'd0);  // refused: full
		offer_item(ACT_EXPIRE, '0, 3'd0, 1'b0, 3'd0);
		offer_item(ACT_EXPIRE, '1, 3'd1, 1'b1, 3'd1);
		offer_item(ACT_ACK, '0, 3'd0, 1'b0, 3'd0);           // corrupt ack
		offer_item(ACT_ACK, '0, 3'd2, 1'b1, 3'd0);           // out of order, no slide
		offer_item(ACT_ACK, '0, 3'd1, 1'b1, 3'd0);
		offer_item(ACT_ACK, '0, 3'd5, 1'b1, 3'd0);           // never sent
		offer_item(ACT_ACK, '0, 3'd0, 1'b1, 3'd0);           // base slides past three
		offer_item(ACT_ACK, '0, 3'd1, 1'b1, 3'd0);           // already passed
		offer_item(ACT_EXPIRE, '0, 3'd0, 1'b0, 3'd2);        // expiry outside the window
		offer_item(ACT_SEND, 64'h8000_0000_0000_0001, 3'd0, 1'b0, 3'd0);
		offer_item(ACT_SEND, 64'hFFFF_0000_FFFF_0000, 3'd0, 1'b0, 3'd0);
		offer_item(ACT_SEND, 64'h0000_FFFF_0000_FFFF, 3'd0, 1'b0, 3'd0);
		offer_item(ACT_SEND, '1, 3'd0, 1'b0, 3'd0);          // refused again
		offer_item(ACT_ACK, '0, 3'd6, 1'b1, 3'd0);
		offer_item(ACT_ACK, '0, 3'd3, 1'b1, 3'd0);
		offer_item(ACT_ACK, '0, 3'd4, 1'b1, 3'd0);
		offer_item(ACT_ACK, '0, 3'd5, 1'b1, 3'd0);           // base catches up with next
		offer_item(ACT_EXPIRE, '0, 3'd0, 1'b0, 3'd6);
		s_axis_tvalid <= 1'b0;
	endtask

	// Mostly well-formed traffic: sends, acks for numbers in flight, expiries of
	// written slots; the rest is corrupt, stray or no-op items.
	task automatic random_item(output act_t act, output logic [WORD_W-1:0] pay,
			output logic [SEQ_W-1:0] ackn, output logic good, output logic [SEQ_W-1:0] expn);
		int roll;
		int span;
		logic [SEQ_W-1:0] slots[$];
		roll = $urandom_range(0, 99);
		pay = pick_payload();
		ackn = SEQ_W'($urandom);
		good = 1'(($urandom));
		expn = SEQ_W'($urandom);
		span = int'(board.in_flight());
		if (roll < 42) begin
			act = ACT_SEND;
		end else if (roll < 70) begin
			act = ACT_ACK;
			good = 1'b1;
			if (span != 0)
				ackn = board.base + SEQ_W'($urandom_range(0, span - 1));
		end else if (roll < 80) begin
			act = ACT_EXPIRE;
			if (span != 0 && $urandom_range(0, 9) < 7) begin
				expn = board.base + SEQ_W'($urandom_range(0, span - 1));
			end else begin
				foreach (board.written[i])
					if (board.written[i])
						slots.push_back(SEQ_W'(i));
				if (slots.size() == 0)
					act = ACT_SEND;
				else
					expn = slots[$urandom_range(0, slots.size() - 1)];
			end
		end else if (roll < 88) begin
			act = ACT_ACK;
			good = 1'b1;
		end else if (roll < 95) begin
			act = ACT_ACK;
			good = 1'b0;
		end else begin
			act = ACT_NONE;
		end
	endtask

	initial begin
		act_t act;
		logic [WORD_W-1:0] pay;
		logic [SEQ_W-1:0] ackn, expn;
		logic good;
		int counted;
		board = new();
		repeat (4) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		run_directed();
		foreach (windows[i]) begin
			settle();
			if (i == windows.size() - 1)
				steady <= 1'b1;
			write_window(WIN_W'(windows[i]));
			counted = 0;
			while (counted < PHASE_ITEMS) begin
				random_item(act, pay, ackn, good, expn);
				offer_item(act, pay, ackn, good, expn);
				counted++;
			end
			s_axis_tvalid <= 1'b0;
		end
		settle();
		board.close_out();
		$display("checked %0d results over %0d window settings: %0d sends taken, %0d refused,",
			board.checked, settings_used, board.sends_taken, board.sends_refused);
		$display("  %0d acks inside the window, %0d outside it, %0d expiries resent",
			board.acks_in_window, board.acks_other, board.expiries);
		if (board.failures == 0)
			$display("Simulation PASSED");
		else
			$display("Simulation FAILED");
		$finish;
	end

endmodule

`default_nettype wire
